// ----- src/fixed_point_requantizer_defines.svh -----
// Assertion macros for the requantizer. The enclosing module must have clk and arst_n.
`ifndef FIXED_POINT_REQUANTIZER_DEFINES_SVH
`define FIXED_POINT_REQUANTIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FPR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPR_ASSERT(lbl, prop, msg)
`define FPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/fpr_pkg.sv -----
`default_nettype none
package fpr_pkg;
	localparam int WORD_BITS_DEF = 64;
	localparam int SHIFT_W = 6;
	localparam int LEN_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROUND_MODE  = 2'd0,
		REG_SIGNED_MODE = 2'd1,
		REG_WORD_LENGTH = 2'd2,
		REG_SATURATE    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		RND_HALF_UP    = 3'd0,
		RND_HALF_ZERO  = 3'd1,
		RND_HALF_DOWN  = 3'd2,
		RND_HALF_AWAY  = 3'd3,
		RND_HALF_EVEN  = 3'd4,
		RND_HALF_ODD   = 3'd5,
		RND_TRUNC      = 3'd6,
		RND_TRUNC_ZERO = 3'd7
	} round_mode_t;

	typedef struct packed {
		logic             signed_mode;
		logic [LEN_W-1:0] word_length;
		logic             saturate;
	} fit_cfg_t;
endpackage
`default_nettype wire

// ----- src/fpr_round.sv -----
`default_nettype none
module fpr_round import fpr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic [WORD_BITS-1:0] value,
	input  wire logic [SHIFT_W-1:0]   shift,
	input  wire round_mode_t          mode,
	output logic [WORD_BITS-1:0]      rounded
);
	localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

	logic                 neg, half, rest, lsb, any_low, inc;
	logic [SHIFT_W-1:0]   shift_m1;
	logic [WORD_BITS-1:0] quot, half_word;

	always_comb begin
		shift_m1  = shift - SHIFT_W'(1);
		neg       = value[WORD_BITS-1];
		quot      = WORD_BITS'($signed(value) >>> shift);
		half_word = value >> shift_m1;
		half      = half_word[0];
		rest      = |(value & ~(ONES << shift_m1));
		any_low   = |(value & ~(ONES << shift));
		lsb       = quot[0];
		case (mode)
			RND_HALF_UP:    inc = half;
			RND_HALF_ZERO:  inc = half && (neg || rest);
			RND_HALF_DOWN:  inc = half && rest;
			RND_HALF_AWAY:  inc = half && (!neg || rest);
			RND_HALF_EVEN:  inc = half && (lsb || rest);
			RND_HALF_ODD:   inc = half && (!lsb || rest);
			RND_TRUNC:      inc = 1'b0;
			default:        inc = neg && any_low;
		endcase
		// A zero shift passes the value through unrounded in every mode.
		if (shift == '0) begin
			rounded = value;
		end else begin
			rounded = quot + WORD_BITS'(inc);
		end
	end
endmodule
`default_nettype wire

// ----- src/fpr_fit.sv -----
`default_nettype none
module fpr_fit import fpr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic [WORD_BITS-1:0] value,
	input  wire fit_cfg_t             cfg,
	output logic [WORD_BITS-1:0]      result,
	output logic                      overflow
);
	localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(WORD_BITS);
	localparam logic [LEN_W-1:0] MAX_ULEN = LEN_W'(WORD_BITS - 1);

	logic [LEN_W-1:0]     len;
	logic [WORD_BITS-1:0] keep, mn, mx, sign_word;
	logic                 below, above, sbit;

	always_comb begin
		if (cfg.signed_mode) begin
			if (cfg.word_length == '0) begin
				len = LEN_W'(1);
			end else if (cfg.word_length > MAX_LEN) begin
				len = MAX_LEN;
			end else begin
				len = cfg.word_length;
			end
		end else begin
			len = (cfg.word_length > MAX_ULEN) ? MAX_ULEN : cfg.word_length;
		end
		keep = ~(ONES << len);
		if (cfg.signed_mode) begin
			mx = ~(ONES << (len - LEN_W'(1)));
			mn = ~mx;
		end else begin
			mx = keep;
			mn = '0;
		end
		below     = $signed(value) < $signed(mn);
		above     = $signed(mx) < $signed(value);
		overflow  = below || above;
		sign_word = value >> (len - LEN_W'(1));
		sbit      = cfg.signed_mode && sign_word[0];
		if (!overflow) begin
			result = value;
		end else if (cfg.saturate) begin
			result = below ? mn : mx;
		end else if (sbit) begin
			result = value | ~keep;
		end else begin
			result = value & keep;
		end
	end
endmodule
`default_nettype wire

// ----- src/fixed_point_requantizer.sv -----
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// request  | req_valid, req_ready, value_in, shift_amount | in
// response | rsp_valid, rsp_ready, value_out, overflow  | out
// config   | cfg_we, cfg_index, cfg_data                | in
//
// One item per cycle is sustained while the response side does not stall.
// Stage one registers the request, stage two holds the rounded value, the output
// register holds the fitted value and the overflow flag.
// A stage takes new data whenever it is empty or its contents move on, so a stall
// on the response side fills the three stages before req_ready drops.
// Reset clears the valid bits and loads the registers: truncate, signed, full width, wrap.
`default_nettype none
`include "fixed_point_requantizer_defines.svh"
module fixed_point_requantizer import fpr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [WORD_BITS-1:0]  value_in,
	input  wire logic [SHIFT_W-1:0]    shift_amount,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic [WORD_BITS-1:0]       value_out,
	output logic                       overflow,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	round_mode_t          round_mode_q;
	fit_cfg_t             fit_cfg_q;
	logic                 valid_s1, valid_s2, valid_q;
	logic [WORD_BITS-1:0] value_s1, round_s2, value_q;
	logic [SHIFT_W-1:0]   shift_s1;
	logic                 ovf_q;
	logic                 ready_o, ready_s2;
	logic [WORD_BITS-1:0] rounded, fitted;
	logic                 fit_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_mode_q          <= RND_TRUNC;
			fit_cfg_q.signed_mode <= 1'b1;
			fit_cfg_q.word_length <= LEN_W'(64);
			fit_cfg_q.saturate    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROUND_MODE:  round_mode_q          <= round_mode_t'(cfg_data[2:0]);
				REG_SIGNED_MODE: fit_cfg_q.signed_mode <= cfg_data[0];
				REG_WORD_LENGTH: fit_cfg_q.word_length <= cfg_data[LEN_W-1:0];
				REG_SATURATE:    fit_cfg_q.saturate    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ready_o   = !valid_q || rsp_ready;
	assign ready_s2  = !valid_s2 || ready_o;
	assign req_ready = !valid_s1 || ready_s2;

	fpr_round #(.WORD_BITS(WORD_BITS)) u_round (
		.value   (value_s1),
		.shift   (shift_s1),
		.mode    (round_mode_q),
		.rounded (rounded)
	);

	fpr_fit #(.WORD_BITS(WORD_BITS)) u_fit (
		.value    (round_s2),
		.cfg      (fit_cfg_q),
		.result   (fitted),
		.overflow (fit_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_o) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			value_s1 <= value_in;
			shift_s1 <= shift_amount;
		end
		if (ready_s2 && valid_s1) begin
			round_s2 <= rounded;
		end
		if (ready_o && valid_s2) begin
			value_q <= fitted;
			ovf_q   <= fit_ovf;
		end
	end

	assign rsp_valid = valid_q;
	assign value_out = value_q;
	assign overflow  = ovf_q;

	// A full-width signed word holds every rounded value.
	`FPR_ASSERT(a_full_width_no_ovf, valid_q && fit_cfg_q.signed_mode && (fit_cfg_q.word_length >= LEN_W'(WORD_BITS)) && $stable(fit_cfg_q) |-> !overflow, "overflow on a full-width signed word")
	// Saturating to an unsigned word never yields a negative result.
	`FPR_ASSERT(a_unsigned_sat_nonneg, valid_q && !fit_cfg_q.signed_mode && fit_cfg_q.saturate && $stable(fit_cfg_q) |-> !value_out[WORD_BITS-1], "negative unsigned saturation result")
	// A rounded value that cannot move on stays in place.
	`FPR_ASSERT(a_s2_holds, valid_s2 && !ready_o |=> valid_s2 && $stable(round_s2), "stage two lost or changed a stalled value")
	`FPR_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !valid_q && !valid_s1 && !valid_s2, "pipeline not empty in reset")
endmodule
`default_nettype wire
